/* hdl/tagged_int_stack_machine_core_top_defines.svh */
// Assertion macros for the tagged integer stack machine core.
// Used by files that carry concurrent checks; expects aclk and aresetn in scope.
`ifndef TAGGED_INT_STACK_MACHINE_CORE_TOP_DEFINES_SVH
`define TAGGED_INT_STACK_MACHINE_CORE_TOP_DEFINES_SVH

// property must hold at every edge outside reset
`define TISM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tism check failed");

// trigger implies the consequence in the next cycle
`define TISM_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("tism sequence check failed");

`endif

/* hdl/tism_pkg.sv */
// Shared types, constants and helpers of the tagged integer stack machine core.
// No dependencies.
package tism_pkg;

    localparam int STACK_DEPTH    = 1024;
    localparam int ADDR_W         = $clog2(STACK_DEPTH);
    localparam int TOP_W          = ADDR_W + 1;
    localparam int CODE_ADDR_BITS = 16;
    localparam int WORD_W         = 64;

    localparam logic [WORD_W-1:0] UNIT_WORD  = 64'd1;
    localparam logic [WORD_W-1:0] FALSE_WORD = 64'd1;
    localparam logic [WORD_W-1:0] TRUE_WORD  = 64'd3;

    typedef enum logic [5:0] {
        OP_ACC = 6'd0, OP_PUSH = 6'd1, OP_PUSHACC = 6'd2, OP_POP = 6'd3,
        OP_ASSIGN = 6'd4, OP_CONSTINT = 6'd5, OP_PUSHCONSTINT = 6'd6, OP_NEGINT = 6'd7,
        OP_ADDINT = 6'd8, OP_SUBINT = 6'd9, OP_MULINT = 6'd10, OP_DIVINT = 6'd11,
        OP_MODINT = 6'd12, OP_ANDINT = 6'd13, OP_ORINT = 6'd14, OP_XORINT = 6'd15,
        OP_LSLINT = 6'd16, OP_LSRINT = 6'd17, OP_ASRINT = 6'd18, OP_EQ = 6'd19,
        OP_NEQ = 6'd20, OP_LTINT = 6'd21, OP_LEINT = 6'd22, OP_GTINT = 6'd23,
        OP_GEINT = 6'd24, OP_ULTINT = 6'd25, OP_UGEINT = 6'd26, OP_BRANCH = 6'd27,
        OP_BRANCHIF = 6'd28, OP_BRANCHIFNOT = 6'd29, OP_BEQ = 6'd30, OP_BNEQ = 6'd31,
        OP_BLTINT = 6'd32, OP_BLEINT = 6'd33, OP_BGTINT = 6'd34, OP_BGEINT = 6'd35,
        OP_BULTINT = 6'd36, OP_BUGEINT = 6'd37, OP_STOP = 6'd38, OP_CHECK_SIGNALS = 6'd39
    } op_t;

    typedef enum logic [1:0] {
        ST_STEP = 2'd0, ST_HALT = 2'd1, ST_DIV_ZERO = 2'd2, ST_FAULT = 2'd3
    } status_t;

    // one classified instruction as it sits in the queue
    typedef struct packed {
        op_t         op;
        logic        is_binary;
        logic [9:0]  slot;
        logic [62:0] imm;
        logic [16:0] off;
    } item_t;

    function automatic logic [WORD_W-1:0] untag(input logic [WORD_W-1:0] w);
        return {w[WORD_W-1], w[WORD_W-1:1]};
    endfunction

    function automatic logic [WORD_W-1:0] tag(input logic [WORD_W-1:0] x);
        return {x[WORD_W-2:0], 1'b1};
    endfunction

endpackage

/* hdl/tism_front.sv */
// Front end: takes instruction requests, classifies them and queues them.
// Depends on tism_pkg.
module tism_front import tism_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // slot_index[9:0], immediate[72:10], branch_offset[89:73]
    input  logic [5:0]  s_tuser,   // operation[5:0]
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t       fifo_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    item_t       in_item;
    logic        push;

    always_comb begin
        in_item.op        = op_t'(s_tuser);
        in_item.is_binary = (s_tuser >= 6'(OP_ADDINT)) && (s_tuser <= 6'(OP_UGEINT));
        in_item.slot      = s_tdata[9:0];
        in_item.imm       = s_tdata[72:10];
        in_item.off       = s_tdata[89:73];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

/* hdl/tism_div.sv */
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating.
// Depends on tism_pkg.
module tism_div import tism_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quot,
    output logic [WORD_W-1:0] rem
);

    logic [WORD_W-1:0] q_reg, r_reg, d_reg;
    logic              neg_q_reg, neg_r_reg, busy_reg, done_reg;
    logic [5:0]        cnt_reg;
    logic [WORD_W:0]   shifted, diff;

    assign shifted = {r_reg, q_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign done    = done_reg;
    assign quot    = neg_q_reg ? -q_reg : q_reg;
    assign rem     = neg_r_reg ? -r_reg : r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 6'h3F);
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                q_reg     <= dividend[WORD_W-1] ? -dividend : dividend;
                d_reg     <= divisor[WORD_W-1] ? -divisor : divisor;
                r_reg     <= '0;
                neg_q_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
                neg_r_reg <= dividend[WORD_W-1];
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'h3F) busy_reg <= 1'b0;
                if (!diff[WORD_W]) begin
                    r_reg <= diff[WORD_W-1:0];
                    q_reg <= {q_reg[WORD_W-2:0], 1'b1};
                end else begin
                    r_reg <= shifted[WORD_W-1:0];
                    q_reg <= {q_reg[WORD_W-2:0], 1'b0};
                end
            end
        end
    end

endmodule

/* hdl/tism_back.sv */
// Back end: executes queued instructions on accumulator, pc and stack memory.
// Depends on tism_pkg, tism_div and the assertion macro header.
`include "tagged_int_stack_machine_core_top_defines.svh"
module tism_back import tism_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // accumulator[63:0], program_counter[79:64]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int SUM_W = ((TOP_W > 10) ? TOP_W : 10) + 1;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MUL, S_DIV} state_t;

    state_t                   state_reg;
    item_t                    cur_reg;
    logic                     fault_reg;
    logic [ADDR_W-1:0]        raddr_reg;
    logic [WORD_W-1:0]        acc_reg, rdata_reg, mp_reg, prod_reg;
    logic [TOP_W-1:0]         top_reg;
    logic [CODE_ADDR_BITS-1:0] pc_reg;
    logic [1:0]               mul_cnt_reg;
    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [WORD_W-1:0]        out_acc_reg;
    logic [CODE_ADDR_BITS-1:0] out_pc_reg;
    logic [WORD_W-1:0]        mem [STACK_DEPTH];

    // issue-time checks
    logic [SUM_W-1:0]         sum_n, sum_n1;
    logic                     issue_fault;
    logic [ADDR_W-1:0]        issue_raddr;

    // execute-time results
    logic [WORD_W-1:0]        rhs, ua, ub, lu, ru, imm64, alu_acc, mul_p;
    logic [31:0]              mul_a, mul_b;
    logic [5:0]               sh;
    logic [CODE_ADDR_BITS-1:0] next_pc, tgt_pc, alu_pc;
    logic [TOP_W-1:0]         alu_top;
    logic                     alu_we, taken;
    status_t                  alu_status;
    logic [ADDR_W-1:0]        waddr;
    logic signed [16:0]       off_s;
    logic                     div_start, div_done;
    logic [WORD_W-1:0]        div_q, div_r;

    assign q_pop = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        sum_n  = SUM_W'(top_reg) + SUM_W'(q_item.slot);
        sum_n1 = sum_n - SUM_W'(1);
        issue_raddr = sum_n[ADDR_W-1:0];
        issue_fault = 1'b0;
        if (q_item.is_binary) begin
            issue_fault = top_reg >= TOP_W'(STACK_DEPTH);
            issue_raddr = top_reg[ADDR_W-1:0];
        end else begin
            unique case (q_item.op)
                OP_ACC, OP_ASSIGN: issue_fault = sum_n >= SUM_W'(STACK_DEPTH);
                OP_PUSH, OP_PUSHCONSTINT: issue_fault = (top_reg == '0);
                OP_PUSHACC: begin
                    issue_fault = (top_reg == '0) || (sum_n1 >= SUM_W'(STACK_DEPTH));
                    issue_raddr = sum_n1[ADDR_W-1:0];
                end
                OP_POP: issue_fault = sum_n > SUM_W'(STACK_DEPTH);
                default: issue_fault = 1'b0;
            endcase
        end
    end

    always_comb begin
        rhs     = rdata_reg;
        ua      = untag(acc_reg);
        ub      = untag(rhs);
        sh      = rhs[6:1];
        imm64   = {cur_reg.imm[62], cur_reg.imm};
        lu      = imm64;
        ru      = ua;
        off_s   = cur_reg.off;
        next_pc = pc_reg + CODE_ADDR_BITS'(1);
        tgt_pc  = pc_reg + CODE_ADDR_BITS'(off_s);
        alu_acc = acc_reg;
        alu_pc  = next_pc;
        alu_top = cur_reg.is_binary ? top_reg + TOP_W'(1) : top_reg;
        alu_we  = 1'b0;
        alu_status = ST_STEP;
        taken   = 1'b0;
        unique case (cur_reg.op)
            OP_ACC: alu_acc = rhs;
            OP_PUSH: begin alu_top = top_reg - TOP_W'(1); alu_we = 1'b1; end
            OP_PUSHACC: begin
                alu_top = top_reg - TOP_W'(1);
                alu_we  = 1'b1;
                alu_acc = (cur_reg.slot == '0) ? acc_reg : rhs;
            end
            OP_PUSHCONSTINT: begin
                alu_top = top_reg - TOP_W'(1);
                alu_we  = 1'b1;
                alu_acc = tag(imm64);
            end
            OP_POP: alu_top = TOP_W'(SUM_W'(top_reg) + SUM_W'(cur_reg.slot));
            OP_ASSIGN: begin alu_we = 1'b1; alu_acc = UNIT_WORD; end
            OP_CONSTINT: alu_acc = tag(imm64);
            OP_NEGINT: alu_acc = 64'd2 - acc_reg;
            OP_ADDINT: alu_acc = acc_reg + rhs - 64'd1;
            OP_SUBINT: alu_acc = acc_reg - rhs + 64'd1;
            OP_ANDINT: alu_acc = acc_reg & rhs;
            OP_ORINT:  alu_acc = acc_reg | rhs;
            OP_XORINT: alu_acc = (acc_reg ^ rhs) | 64'd1;
            OP_LSLINT: alu_acc = ((acc_reg - 64'd1) << sh) + 64'd1;
            OP_LSRINT: alu_acc = (acc_reg >> sh) | 64'd1;
            OP_ASRINT: alu_acc = 64'($signed(acc_reg) >>> sh) | 64'd1;
            OP_EQ:  alu_acc = (acc_reg == rhs) ? TRUE_WORD : FALSE_WORD;
            OP_NEQ: alu_acc = (acc_reg != rhs) ? TRUE_WORD : FALSE_WORD;
            OP_LTINT: alu_acc = ($signed(acc_reg) < $signed(rhs)) ? TRUE_WORD : FALSE_WORD;
            OP_LEINT: alu_acc = ($signed(acc_reg) <= $signed(rhs)) ? TRUE_WORD : FALSE_WORD;
            OP_GTINT: alu_acc = ($signed(acc_reg) > $signed(rhs)) ? TRUE_WORD : FALSE_WORD;
            OP_GEINT: alu_acc = ($signed(acc_reg) >= $signed(rhs)) ? TRUE_WORD : FALSE_WORD;
            OP_ULTINT: alu_acc = (acc_reg < rhs) ? TRUE_WORD : FALSE_WORD;
            OP_UGEINT: alu_acc = (acc_reg >= rhs) ? TRUE_WORD : FALSE_WORD;
            OP_BRANCH: alu_pc = tgt_pc;
            OP_BRANCHIF: alu_pc = (acc_reg != FALSE_WORD) ? tgt_pc : next_pc;
            OP_BRANCHIFNOT: alu_pc = (acc_reg == FALSE_WORD) ? tgt_pc : next_pc;
            OP_BEQ, OP_BNEQ, OP_BLTINT, OP_BLEINT,
            OP_BGTINT, OP_BGEINT, OP_BULTINT, OP_BUGEINT: begin
                unique case (cur_reg.op)
                    OP_BEQ:    taken = lu == ru;
                    OP_BNEQ:   taken = lu != ru;
                    OP_BLTINT: taken = $signed(lu) < $signed(ru);
                    OP_BLEINT: taken = $signed(lu) <= $signed(ru);
                    OP_BGTINT: taken = $signed(lu) > $signed(ru);
                    OP_BGEINT: taken = $signed(lu) >= $signed(ru);
                    OP_BULTINT: taken = lu < ru;
                    default:   taken = lu >= ru;
                endcase
                alu_pc = taken ? tgt_pc : next_pc;
            end
            OP_STOP: begin alu_status = ST_HALT; alu_pc = pc_reg; end
            default: alu_pc = next_pc;
        endcase
    end

    // 64x64 low product from three 32x32 partial products
    always_comb begin
        unique case (mul_cnt_reg)
            2'd0:    begin mul_a = ua[31:0];  mul_b = ub[31:0];  end
            2'd1:    begin mul_a = ua[31:0];  mul_b = ub[63:32]; end
            default: begin mul_a = ua[63:32]; mul_b = ub[31:0];  end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    assign waddr     = (cur_reg.op == OP_ASSIGN) ? raddr_reg
                                                 : ADDR_W'(top_reg - TOP_W'(1));
    assign div_start = (state_reg == S_EXEC) && !fault_reg && (ub != '0) &&
                       (cur_reg.op == OP_DIVINT || cur_reg.op == OP_MODINT);

    tism_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ua),
        .divisor  (ub),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_ff @(posedge aclk) begin
        if (q_pop) rdata_reg <= mem[issue_raddr];
        if (state_reg == S_EXEC && !fault_reg && alu_we) mem[waddr] <= acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            acc_reg       <= UNIT_WORD;
            top_reg       <= TOP_W'(STACK_DEPTH);
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            mul_cnt_reg   <= '0;
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        cur_reg   <= q_item;
                        fault_reg <= issue_fault;
                        raddr_reg <= issue_raddr;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (fault_reg) begin
                        out_status_reg <= ST_FAULT;
                        out_acc_reg    <= acc_reg;
                        out_pc_reg     <= pc_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end else if (cur_reg.op == OP_MULINT) begin
                        top_reg     <= alu_top;
                        mul_cnt_reg <= '0;
                        state_reg   <= S_MUL;
                    end else if (cur_reg.op == OP_DIVINT || cur_reg.op == OP_MODINT) begin
                        top_reg <= alu_top;
                        if (ub == '0) begin
                            out_status_reg <= ST_DIV_ZERO;
                            out_acc_reg    <= acc_reg;
                            out_pc_reg     <= pc_reg;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_IDLE;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end else begin
                        acc_reg        <= alu_acc;
                        pc_reg         <= alu_pc;
                        top_reg        <= alu_top;
                        out_status_reg <= alu_status;
                        out_acc_reg    <= alu_acc;
                        out_pc_reg     <= alu_pc;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_MUL: begin
                    mul_cnt_reg <= mul_cnt_reg + 2'd1;
                    mp_reg      <= mul_p;
                    unique case (mul_cnt_reg)
                        2'd0: ;
                        2'd1: prod_reg <= mp_reg;
                        2'd2: prod_reg <= prod_reg + {mp_reg[31:0], 32'd0};
                        default: begin
                            acc_reg        <= tag(prod_reg + {mp_reg[31:0], 32'd0});
                            pc_reg         <= next_pc;
                            out_status_reg <= ST_STEP;
                            out_acc_reg    <= tag(prod_reg + {mp_reg[31:0], 32'd0});
                            out_pc_reg     <= next_pc;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        acc_reg        <= tag((cur_reg.op == OP_DIVINT) ? div_q : div_r);
                        pc_reg         <= next_pc;
                        out_status_reg <= ST_STEP;
                        out_acc_reg    <= tag((cur_reg.op == OP_DIVINT) ? div_q : div_r);
                        out_pc_reg     <= next_pc;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {16'(out_pc_reg), out_acc_reg};

    `TISM_ASSERT(a_top_in_range, top_reg <= TOP_W'(STACK_DEPTH))
    `TISM_ASSERT_NEXT(a_fault_keeps_stack, state_reg == S_EXEC && fault_reg, $stable(top_reg))
    `TISM_ASSERT(a_busy_out_empty, state_reg != S_IDLE |-> !out_valid_reg)
    `TISM_ASSERT(a_div_done_in_div, div_done |-> state_reg == S_DIV)

endmodule

/* hdl/tagged_int_stack_machine_core_top.sv */
// Top level of the tagged integer stack machine core.
// Depends on tism_pkg, tism_front and tism_back (which uses tism_div).
//
// Executes one decoded bytecode instruction per input request on a 64-bit
// accumulator and a downward-growing stack of 1024 words; integers are kept
// tagged as 2x+1. Each request yields exactly one result: status, new
// accumulator and new program counter. In the back end most instructions
// first read the stack memory port, then execute and write back; MULINT
// runs through a shared 32x32 multiplier, and DIVINT/MODINT through the
// bit-serial divider. The front end queues up to two requests, so the
// input side keeps accepting until the queue is full while the back end
// works or a result waits for m_tready. After reset the stack is empty and
// its contents are undefined until pushed; no clearing pass runs.
module tagged_int_stack_machine_core_top import tism_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // instruction requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // slot_index[9:0], immediate[72:10], branch_offset[89:73]
    input  logic [5:0]  s_tuser,   // operation[5:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // accumulator[63:0], program_counter[79:64]
    output logic [1:0]  m_tuser    // status[1:0]
);

    logic  q_valid, q_pop;
    item_t q_item;

    // front: accept and classify into a two-entry queue
    tism_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: execute against the architectural state, register the result
    tism_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
